@@ rtl/cartesian_to_polar_radar_core_defines.svh @@
// ----------------------------------------------------------------------------
// Cartesian to polar radar core assertion macros
// Shared macros for the concurrent checks of the core.
// ----------------------------------------------------------------------------
`ifndef CARTESIAN_TO_POLAR_RADAR_CORE_DEFINES_SVH
`define CARTESIAN_TO_POLAR_RADAR_CORE_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define C2P_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check an implication on every rising clock edge outside reset.
`define C2P_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ rtl/c2p_pkg.sv @@
// ----------------------------------------------------------------------------
// Cartesian to polar package
// Widths, constants, stage types and the arctangent table of the core.
// ----------------------------------------------------------------------------
package c2p_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned FRAC_BITS     = 16;
  localparam int unsigned CORDIC_STAGES = 20;
  localparam int unsigned SQRT_STAGES   = 32;
  localparam int unsigned DIV_STAGES    = 64;
  localparam int unsigned CX_W          = 51;
  localparam int unsigned Z_W           = 35;
  localparam int unsigned BEAR_W        = 19;
  localparam int unsigned RR_W          = 33;
  localparam int unsigned MINR_W        = 16;

  localparam logic signed [Z_W-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 35'sd1686629713;

  // One CORDIC rotation state.
  typedef struct packed {
    logic signed [CX_W-1:0] x;
    logic signed [CX_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   fixed;
  } cordic_t;

  // Products that travel beside the CORDIC.
  typedef struct packed {
    logic [63:0]        pxx;
    logic [63:0]        pyy;
    logic signed [63:0] pxvx;
    logic signed [63:0] pyvy;
  } prod_t;

  // Square root state and its side data.
  typedef struct packed {
    logic [35:0] rem;
    logic [31:0] root;
    logic [63:0] n;
  } sqrt_t;

  typedef struct packed {
    logic [63:0]       mag;
    logic              neg;
    logic [BEAR_W-1:0] bearing;
  } sqs_t;

  // Divider state and its side data.
  typedef struct packed {
    logic [31:0] rem;
    logic [63:0] nq;
    logic [31:0] d;
  } div_t;

  typedef struct packed {
    logic [BEAR_W-1:0] bearing;
    logic [31:0]       range;
    logic              neg;
    logic              short_rng;
  } dvs_t;

  // atan(2^-i) in Q2.30, truncated.
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd843314856;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043836;
      5'd3:  v = 30'd133525158;
      5'd4:  v = 30'd67021686;
      5'd5:  v = 30'd33543515;
      5'd6:  v = 30'd16775850;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194282;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048575;
      5'd11: v = 30'd524287;
      5'd12: v = 30'd262143;
      5'd13: v = 30'd131071;
      5'd14: v = 30'd65535;
      5'd15: v = 30'd32767;
      5'd16: v = 30'd16383;
      5'd17: v = 30'd8191;
      5'd18: v = 30'd4095;
      5'd19: v = 30'd2047;
      5'd20: v = 30'd1023;
      5'd21: v = 30'd511;
      5'd22: v = 30'd255;
      5'd23: v = 30'd127;
      5'd24: v = 30'd63;
      5'd25: v = 30'd31;
      5'd26: v = 30'd15;
      5'd27: v = 30'd7;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/c2p_cordic.sv @@
// ----------------------------------------------------------------------------
// Cartesian to polar CORDIC
// Vectoring CORDIC pipeline, one rotation per stage, with side data.
// ----------------------------------------------------------------------------
module c2p_cordic (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  c2p_pkg::cordic_t                    data_i,
  input  c2p_pkg::prod_t                      side_i,
  output logic                                valid_o,
  output logic signed [c2p_pkg::Z_W-1:0]      z_o,
  output c2p_pkg::prod_t                      side_o
);
  import c2p_pkg::*;

  logic [CORDIC_STAGES-1:0] vld_q;
  cordic_t st_q [CORDIC_STAGES];
  prod_t   sd_q [CORDIC_STAGES];
  cordic_t st_in [CORDIC_STAGES];
  cordic_t st_nx [CORDIC_STAGES];
  prod_t   sd_in [CORDIC_STAGES];
  logic [CORDIC_STAGES-1:0] vld_in;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    logic signed [CX_W-1:0] xs, ys;
    logic signed [Z_W-1:0]  ang;

    // Stage input comes from the port or the previous stage.
    if (k == 0) begin : g_first
      assign st_in[k]  = data_i;
      assign sd_in[k]  = side_i;
      assign vld_in[k] = valid_i;
    end else begin : g_next
      assign st_in[k]  = st_q[k-1];
      assign sd_in[k]  = sd_q[k-1];
      assign vld_in[k] = vld_q[k-1];
    end

    // One rotation toward the x axis.
    assign xs  = st_in[k].x >>> k;
    assign ys  = st_in[k].y >>> k;
    assign ang = $signed({5'b0, atan_q30(5'(k))});

    always_comb begin
      st_nx[k] = st_in[k];
      if (!st_in[k].fixed) begin
        if (!st_in[k].y[CX_W-1]) begin
          st_nx[k].x = st_in[k].x + ys;
          st_nx[k].y = st_in[k].y - xs;
          st_nx[k].z = st_in[k].z + ang;
        end else begin
          st_nx[k].x = st_in[k].x - ys;
          st_nx[k].y = st_in[k].y + xs;
          st_nx[k].z = st_in[k].z - ang;
        end
      end
    end

    // Valid bits reset; payload follows them.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= st_nx[k];
        sd_q[k] <= sd_in[k];
      end
    end
  end

  assign valid_o = vld_q[CORDIC_STAGES-1];
  assign z_o     = st_q[CORDIC_STAGES-1].z;
  assign side_o  = sd_q[CORDIC_STAGES-1];

endmodule

@@ rtl/c2p_isqrt.sv @@
// ----------------------------------------------------------------------------
// Cartesian to polar square root
// Pipelined restoring integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module c2p_isqrt (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [63:0]    n_i,
  input  c2p_pkg::sqs_t  side_i,
  output logic           valid_o,
  output logic [31:0]    root_o,
  output c2p_pkg::sqs_t  side_o
);
  import c2p_pkg::*;

  logic [SQRT_STAGES-1:0] vld_q;
  logic [SQRT_STAGES-1:0] vld_in;
  sqrt_t st_q  [SQRT_STAGES];
  sqrt_t st_in [SQRT_STAGES];
  sqrt_t st_nx [SQRT_STAGES];
  sqs_t  sd_q  [SQRT_STAGES];
  sqs_t  sd_in [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    logic [35:0] rr, trial;

    if (k == 0) begin : g_first
      assign st_in[k]  = '{rem: '0, root: '0, n: n_i};
      assign sd_in[k]  = side_i;
      assign vld_in[k] = valid_i;
    end else begin : g_next
      assign st_in[k]  = st_q[k-1];
      assign sd_in[k]  = sd_q[k-1];
      assign vld_in[k] = vld_q[k-1];
    end

    // Bring down two bits and try the next root bit.
    assign rr    = {st_in[k].rem[33:0], st_in[k].n[63:62]};
    assign trial = {2'b00, st_in[k].root, 2'b01};

    always_comb begin
      st_nx[k].n = {st_in[k].n[61:0], 2'b00};
      if (rr >= trial) begin
        st_nx[k].rem  = rr - trial;
        st_nx[k].root = {st_in[k].root[30:0], 1'b1};
      end else begin
        st_nx[k].rem  = rr;
        st_nx[k].root = {st_in[k].root[30:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= st_nx[k];
        sd_q[k] <= sd_in[k];
      end
    end
  end

  assign valid_o = vld_q[SQRT_STAGES-1];
  assign root_o  = st_q[SQRT_STAGES-1].root;
  assign side_o  = sd_q[SQRT_STAGES-1];

endmodule

@@ rtl/c2p_divider.sv @@
// ----------------------------------------------------------------------------
// Cartesian to polar divider
// Pipelined restoring 64 by 32 bit unsigned divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module c2p_divider (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [63:0]    dividend_i,
  input  logic [31:0]    divisor_i,
  input  c2p_pkg::dvs_t  side_i,
  output logic           valid_o,
  output logic [63:0]    quot_o,
  output c2p_pkg::dvs_t  side_o
);
  import c2p_pkg::*;

  logic [DIV_STAGES-1:0] vld_q;
  logic [DIV_STAGES-1:0] vld_in;
  div_t st_q  [DIV_STAGES];
  div_t st_in [DIV_STAGES];
  div_t st_nx [DIV_STAGES];
  dvs_t sd_q  [DIV_STAGES];
  dvs_t sd_in [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [32:0] t, dd;
    logic        ge;

    if (k == 0) begin : g_first
      assign st_in[k]  = '{rem: '0, nq: dividend_i, d: divisor_i};
      assign sd_in[k]  = side_i;
      assign vld_in[k] = valid_i;
    end else begin : g_next
      assign st_in[k]  = st_q[k-1];
      assign sd_in[k]  = sd_q[k-1];
      assign vld_in[k] = vld_q[k-1];
    end

    // Shift in one dividend bit and subtract the divisor where it fits.
    assign t  = {st_in[k].rem, st_in[k].nq[63]};
    assign dd = {1'b0, st_in[k].d};
    assign ge = (t >= dd);

    always_comb begin
      st_nx[k].d   = st_in[k].d;
      st_nx[k].nq  = {st_in[k].nq[62:0], ge};
      st_nx[k].rem = ge ? 32'(t - dd) : t[31:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= st_nx[k];
        sd_q[k] <= sd_in[k];
      end
    end
  end

  assign valid_o = vld_q[DIV_STAGES-1];
  assign quot_o  = st_q[DIV_STAGES-1].nq;
  assign side_o  = sd_q[DIV_STAGES-1];

endmodule

@@ rtl/cartesian_to_polar_radar_core.sv @@
// Path: an accepted input item passes the product register and the CORDIC, sum, square
// root, compare and divider stages before its result is loaded into the output register.
// Throughput: one item per cycle while the skid register is empty; all these stages
// advance together as one chain, held by the same enable when the skid register is full.
// Stalls: a skid register behind the output holds one extra result, so input is taken
// until both are full. Reset clears all valid bits and sets min_range to zero.
// ----------------------------------------------------------------------------
// Cartesian to polar radar core
// Converts a target position and velocity into range, bearing and range rate.
// ----------------------------------------------------------------------------
`include "cartesian_to_polar_radar_core_defines.svh"

module cartesian_to_polar_radar_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration: min_range.
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [15:0]  cfg_data_i,
  // Fields from bit 0: pos_x[31:0], pos_y[63:32], vel_x[95:64], vel_y[127:96].
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [127:0] s_axis_tdata_i,
  // Fields from bit 0: range[31:0], bearing[50:32], range_rate[83:51], zero pad.
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [87:0]  m_axis_tdata_o,
  // Fields from bit 0: range_too_small[0].
  output logic         m_axis_tuser_o
);
  import c2p_pkg::*;

  logic en;
  logic [MINR_W-1:0] min_range_q;

  // Configuration register.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_range_q <= '0;
    end else if (cfg_valid_i) begin
      min_range_q <= cfg_data_i;
    end
  end

  // Input fields.
  logic signed [31:0] px, py, vx, vy;
  assign px = s_axis_tdata_i[31:0];
  assign py = s_axis_tdata_i[63:32];
  assign vx = s_axis_tdata_i[95:64];
  assign vy = s_axis_tdata_i[127:96];

  // CORDIC start point, with the axis cases settled up front.
  cordic_t cinit;
  logic signed [CX_W-1:0] x0, y0;
  assign x0 = {{(CX_W-48){px[31]}}, px, 16'h0000};
  assign y0 = {{(CX_W-48){py[31]}}, py, 16'h0000};

  always_comb begin
    cinit = '{x: x0, y: y0, z: '0, fixed: 1'b0};
    if (py == 32'sd0) begin
      cinit.fixed = 1'b1;
      cinit.z     = px[31] ? PI_Q30 : '0;
    end else if (px == 32'sd0) begin
      cinit.fixed = 1'b1;
      cinit.z     = py[31] ? -HALF_PI_Q30 : HALF_PI_Q30;
    end else if (px[31]) begin
      cinit.x = -x0;
      cinit.y = -y0;
      cinit.z = py[31] ? -PI_Q30 : PI_Q30;
    end
  end

  // Product stage.
  logic    vld_p_q;
  cordic_t cord_p_q;
  prod_t   prod_p_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_p_q <= 1'b0;
    end else if (en) begin
      vld_p_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cord_p_q      <= cinit;
      prod_p_q.pxx  <= 64'(px) * 64'(px);
      prod_p_q.pyy  <= 64'(py) * 64'(py);
      prod_p_q.pxvx <= 64'(px) * 64'(vx);
      prod_p_q.pyvy <= 64'(py) * 64'(vy);
    end
  end

  // Bearing.
  logic                  vld_c;
  logic signed [Z_W-1:0] z_c;
  prod_t                 prod_c;
  c2p_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld_p_q),
    .data_i  (cord_p_q),
    .side_i  (prod_p_q),
    .valid_o (vld_c),
    .z_o     (z_c),
    .side_o  (prod_c)
  );

  // Sum stage: square sum, dot product magnitude and rounded bearing.
  logic signed [Z_W-1:0] z_cl, z_rd;
  logic signed [64:0]    dot;
  always_comb begin
    if (z_c > PI_Q30) begin
      z_cl = PI_Q30;
    end else if (z_c < -PI_Q30) begin
      z_cl = -PI_Q30;
    end else begin
      z_cl = z_c;
    end
    z_rd = (z_cl + (Z_W'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    dot  = 65'(prod_c.pxvx) + 65'(prod_c.pyvy);
  end

  logic        vld_s_q;
  logic [63:0] sq_s_q;
  sqs_t        sqs_s_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_s_q <= 1'b0;
    end else if (en) begin
      vld_s_q <= vld_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_s_q          <= prod_c.pxx + prod_c.pyy;
      sqs_s_q.mag     <= dot[64] ? 64'(-dot) : dot[63:0];
      sqs_s_q.neg     <= dot[64];
      sqs_s_q.bearing <= z_rd[BEAR_W-1:0];
    end
  end

  // Range.
  logic        vld_r;
  logic [31:0] root_r;
  sqs_t        sqs_r;
  c2p_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld_s_q),
    .n_i     (sq_s_q),
    .side_i  (sqs_s_q),
    .valid_o (vld_r),
    .root_o  (root_r),
    .side_o  (sqs_r)
  );

  // Compare stage: minimum range test and divider load.
  logic        vld_m_q;
  logic [63:0] mag_m_q;
  logic [31:0] rng_m_q;
  dvs_t        dvs_m_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_m_q <= 1'b0;
    end else if (en) begin
      vld_m_q <= vld_r;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_m_q           <= sqs_r.mag;
      rng_m_q           <= root_r;
      dvs_m_q.bearing   <= sqs_r.bearing;
      dvs_m_q.range     <= root_r;
      dvs_m_q.neg       <= sqs_r.neg;
      dvs_m_q.short_rng <= (root_r <= {16'h0000, min_range_q});
    end
  end

  // Range rate.
  logic        vld_d;
  logic [63:0] quot_d;
  dvs_t        dvs_d;
  c2p_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (vld_m_q),
    .dividend_i (mag_m_q),
    .divisor_i  (rng_m_q),
    .side_i     (dvs_m_q),
    .valid_o    (vld_d),
    .quot_o     (quot_d),
    .side_o     (dvs_d)
  );

  // Saturate and pack the result item.
  logic [RR_W-1:0] rr;
  logic [88:0]     res;
  always_comb begin
    if (dvs_d.short_rng) begin
      rr = '0;
    end else if (dvs_d.neg) begin
      rr = (quot_d > 64'h1_0000_0000) ? 33'h1_0000_0000 : 33'(64'd0 - quot_d);
    end else begin
      rr = (quot_d > 64'h0_FFFF_FFFF) ? 33'h0_FFFF_FFFF : quot_d[32:0];
    end
    res = {dvs_d.short_rng, 4'h0, rr, dvs_d.bearing, dvs_d.range};
  end

  // Output register with a skid register behind it.
  logic        out_vld_q, skid_vld_q;
  logic [88:0] out_q, skid_q;
  logic        take;
  assign take = out_vld_q && m_axis_tready_i;
  assign en   = !skid_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (take) begin
        skid_vld_q <= 1'b0;
      end
    end else if (vld_d) begin
      if (out_vld_q && !m_axis_tready_i) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (vld_d) begin
      if (out_vld_q && !m_axis_tready_i) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q[87:0];
  assign m_axis_tuser_o  = out_q[88];

  // The skid register only fills behind a held output item.
  `C2P_ASSERT_IMP(a_skid_behind_out, skid_vld_q, out_vld_q, "skid full while output empty")
  // A short range always comes with a zero range rate.
  `C2P_ASSERT_IMP(a_small_zero_rate, out_vld_q && out_q[88], out_q[83:51] == '0,
                  "range rate not zero for short range")
  // Bearing stays within plus and minus pi.
  `C2P_ASSERT_IMP(a_bearing_range, out_vld_q,
                  ($signed(out_q[50:32]) <= 19'sd205887) &&
                  ($signed(out_q[50:32]) >= -19'sd205887), "bearing outside pi")

endmodule
